// ----- hw/rtl/sbc_pkg.sv -----
// Shared types and constants for the segment versus grown-box corridor check.
// Used by the compare unit, the datapath, the controller and the top level.
// Depends on nothing else.
package sbc_pkg;

	// Field widths of the external interface.
	localparam int POS_W  = 32;
	localparam int DIR_W  = 16;
	localparam int SIZE_W = 31;
	localparam int CFG_W  = 31;
	localparam int CFG_IDX_W = 1;

	// Fraction bits of the direction vector.
	localparam int DIR_FRAC_BITS = 14;

	// Internal widths. Doubled positions keep half a box size exact.
	localparam int O2_W   = POS_W + 1;
	localparam int NUM_W  = POS_W + 3;
	localparam int DEN_W  = DIR_W + 1;
	localparam int PROD_W = NUM_W + DEN_W + 1;

	// Register reset values: lookahead 1.0 and clearance 0.5 in Q16.16.
	localparam logic [CFG_W-1:0] LOOKAHEAD_RESET = CFG_W'(65536);
	localparam logic [CFG_W-1:0] CLEARANCE_RESET = CFG_W'(32768);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOKAHEAD = 1'b0,
		REG_CLEARANCE = 1'b1
	} cfg_reg_t;

	// Exact rational value; the denominator is always positive.
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic        [DEN_W-1:0] den;
	} frac_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture a new transaction
		logic prep;   // form entry and exit times, reset the interval
		logic upd;    // narrow the interval from the step-one compares
		logic step2;  // compare unit checks tMax < tMin
		logic axis;   // 0 = X, 1 = Z
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic enabled;
		logic last;
		logic dzero;    // selected axis has a zero direction component
		logic contain;  // origin lies inside the grown span of that axis
		logic miss;     // interval became empty
	} sts_t;

endpackage

// ----- hw/rtl/segment_box_corridor_check_core.sv -----
// Segment versus grown-box corridor check, top level.
// Each box skips both axes when disabled, takes only the containment tests when both
// direction components are zero and otherwise makes two passes per axis through the
// shared cross-multiply compare pair, a multiply step and a compare step each.
// A last box loads the result register as it leaves the finish state.
// Reset is asynchronous: registers return to 1.0 and 0.5, hit memory clears.
module segment_box_corridor_check_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [sbc_pkg::POS_W-1:0] origin_x,
	input  logic signed [sbc_pkg::POS_W-1:0] origin_z,
	input  logic signed [sbc_pkg::DIR_W-1:0] dir_x,
	input  logic signed [sbc_pkg::DIR_W-1:0] dir_z,
	input  logic signed [sbc_pkg::POS_W-1:0] box_center_x,
	input  logic signed [sbc_pkg::POS_W-1:0] box_center_z,
	input  logic [sbc_pkg::SIZE_W-1:0]    box_size_x,
	input  logic [sbc_pkg::SIZE_W-1:0]    box_size_z,
	input  logic                          box_enabled,
	input  logic                          last_box,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          corridor_clear
);
	import sbc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer and result register.
	sbc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.corridor_clear (corridor_clear),
		.sts            (sts),
		.cmd            (cmd)
	);

	// Arithmetic and configuration.
	sbc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.origin_x     (origin_x),
		.origin_z     (origin_z),
		.dir_x        (dir_x),
		.dir_z        (dir_z),
		.box_center_x (box_center_x),
		.box_center_z (box_center_z),
		.box_size_x   (box_size_x),
		.box_size_z   (box_size_z),
		.box_enabled  (box_enabled),
		.last_box     (last_box),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ----- hw/rtl/sbc_frac_cmp.sv -----
// Registered cross-multiply compare of two fractions: a < b.
// Depends on sbc_pkg for the fraction type and widths.
module sbc_frac_cmp (
	input  logic          clk,
	input  sbc_pkg::frac_t a,
	input  sbc_pkg::frac_t b,
	output logic          lt
);
	import sbc_pkg::*;

	logic signed [DEN_W:0]    a_den_s;
	logic signed [DEN_W:0]    b_den_s;
	logic signed [PROD_W-1:0] p1_s1;
	logic signed [PROD_W-1:0] p2_s1;

	assign a_den_s = $signed({1'b0, a.den});
	assign b_den_s = $signed({1'b0, b.den});

	// Both cross products are registered, the compare follows next cycle.
	always_ff @(posedge clk) begin
		p1_s1 <= PROD_W'(a.num) * PROD_W'(b_den_s);
		p2_s1 <= PROD_W'(b.num) * PROD_W'(a_den_s);
	end

	assign lt = (p1_s1 < p2_s1);

endmodule

// ----- hw/rtl/sbc_datapath.sv -----
// Datapath: configuration registers, grown box spans, interval registers
// and two shared fraction compare units. Depends on sbc_pkg, sbc_frac_cmp.
module sbc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbc_pkg::CFG_W-1:0]     cfg_data,
	input  logic signed [sbc_pkg::POS_W-1:0] origin_x,
	input  logic signed [sbc_pkg::POS_W-1:0] origin_z,
	input  logic signed [sbc_pkg::DIR_W-1:0] dir_x,
	input  logic signed [sbc_pkg::DIR_W-1:0] dir_z,
	input  logic signed [sbc_pkg::POS_W-1:0] box_center_x,
	input  logic signed [sbc_pkg::POS_W-1:0] box_center_z,
	input  logic [sbc_pkg::SIZE_W-1:0]    box_size_x,
	input  logic [sbc_pkg::SIZE_W-1:0]    box_size_z,
	input  logic                          box_enabled,
	input  logic                          last_box,
	input  sbc_pkg::cmd_t                 cmd,
	output sbc_pkg::sts_t                 sts
);
	import sbc_pkg::*;

	logic [CFG_W-1:0] lookahead_q;
	logic [CFG_W-1:0] clearance_q;

	logic signed [POS_W-1:0]  org_in  [2];
	logic signed [DIR_W-1:0]  dir_in  [2];
	logic signed [POS_W-1:0]  ctr_in  [2];
	logic        [SIZE_W-1:0] size_in [2];

	logic signed [NUM_W-1:0] r2;
	logic signed [NUM_W-1:0] lo2_d [2];
	logic signed [NUM_W-1:0] hi2_d [2];
	logic signed [DIR_W:0]   dext  [2];
	logic signed [DIR_W:0]   dmag  [2];

	logic signed [O2_W-1:0]  o2_q    [2];
	logic signed [NUM_W-1:0] lo2_q   [2];
	logic signed [NUM_W-1:0] hi2_q   [2];
	logic        [DEN_W-1:0] den_q   [2];
	logic                    dneg_q  [2];
	logic                    dzero_q [2];
	logic                    enabled_q;
	logic                    last_q;

	logic signed [NUM_W-1:0] o2e     [2];
	logic signed [NUM_W-1:0] enter_q [2];
	logic signed [NUM_W-1:0] leave_q [2];
	logic                    contain_q [2];

	frac_t tmin_q;
	frac_t tmax_q;
	frac_t enter_f;
	frac_t leave_f;
	frac_t cmp_a_a;
	frac_t cmp_a_b;
	logic  lt_a;
	logic  lt_b;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= LOOKAHEAD_RESET;
			clearance_q <= CLEARANCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOOKAHEAD: lookahead_q <= cfg_data;
				REG_CLEARANCE: clearance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign org_in[0]  = origin_x;
	assign org_in[1]  = origin_z;
	assign dir_in[0]  = dir_x;
	assign dir_in[1]  = dir_z;
	assign ctr_in[0]  = box_center_x;
	assign ctr_in[1]  = box_center_z;
	assign size_in[0] = box_size_x;
	assign size_in[1] = box_size_z;

	assign r2 = $signed({3'b000, clearance_q, 1'b0});

	// Doubled grown span and direction magnitude, formed at the transaction.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			lo2_d[i] = $signed({ {2{ctr_in[i][POS_W-1]}}, ctr_in[i], 1'b0 })
				- $signed({4'b0000, size_in[i]}) - r2;
			hi2_d[i] = $signed({ {2{ctr_in[i][POS_W-1]}}, ctr_in[i], 1'b0 })
				+ $signed({4'b0000, size_in[i]}) + r2;
			dext[i]  = $signed({dir_in[i][DIR_W-1], dir_in[i]});
			dmag[i]  = dir_in[i][DIR_W-1] ? -dext[i] : dext[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 2; i++) begin
				o2_q[i]    <= $signed({org_in[i], 1'b0});
				lo2_q[i]   <= lo2_d[i];
				hi2_q[i]   <= hi2_d[i];
				den_q[i]   <= {dmag[i][DIR_W-1:0], 1'b0};
				dneg_q[i]  <= dir_in[i][DIR_W-1];
				dzero_q[i] <= (dir_in[i] == '0);
			end
			enabled_q <= box_enabled;
			last_q    <= last_box;
		end
	end

	// Entry and exit times per axis, plus the containment test.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			o2e[i] = NUM_W'(o2_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			for (int i = 0; i < 2; i++) begin
				enter_q[i]   <= dneg_q[i] ? (o2e[i] - hi2_q[i]) : (lo2_q[i] - o2e[i]);
				leave_q[i]   <= dneg_q[i] ? (o2e[i] - lo2_q[i]) : (hi2_q[i] - o2e[i]);
				contain_q[i] <= !((o2e[i] < lo2_q[i]) || (o2e[i] > hi2_q[i]));
			end
		end
	end

	assign enter_f = '{num: enter_q[cmd.axis], den: den_q[cmd.axis]};
	assign leave_f = '{num: leave_q[cmd.axis], den: den_q[cmd.axis]};

	// Lane A tests tMin < enter in step one, tMax < tMin in step two.
	assign cmp_a_a = cmd.step2 ? tmax_q : tmin_q;
	assign cmp_a_b = cmd.step2 ? tmin_q : enter_f;

	sbc_frac_cmp u_cmp_a (
		.clk (clk),
		.a   (cmp_a_a),
		.b   (cmp_a_b),
		.lt  (lt_a)
	);

	// Lane B tests leave < tMax.
	sbc_frac_cmp u_cmp_b (
		.clk (clk),
		.a   (leave_f),
		.b   (tmax_q),
		.lt  (lt_b)
	);

	// Interval registers.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			tmin_q <= '{num: '0, den: DEN_W'(1)};
			tmax_q <= '{num: NUM_W'(lookahead_q), den: DEN_W'(1) << DIR_FRAC_BITS};
		end else if (cmd.upd) begin
			if (lt_a) begin
				tmin_q <= enter_f;
			end
			if (lt_b) begin
				tmax_q <= leave_f;
			end
		end
	end

	assign sts.enabled = enabled_q;
	assign sts.last    = last_q;
	assign sts.dzero   = dzero_q[cmd.axis];
	assign sts.contain = contain_q[cmd.axis];
	assign sts.miss    = lt_a;

endmodule

// ----- hw/rtl/sbc_ctrl.sv -----
// Controller: sequences each box through both axes, keeps the hit memory
// and holds the result register. Depends on sbc_pkg.
module sbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          corridor_clear,
	input  sbc_pkg::sts_t sts,
	output sbc_pkg::cmd_t cmd
);
	import sbc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_AXIS,
		ST_UPD,
		ST_MUL2,
		ST_CHK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   axis_q;
	logic   hit_q;
	logic   hit_seen_q;
	logic   out_valid_q;
	logic   clear_q;
	logic   accept;
	logic   out_free;

	assign in_ready       = (state_q == ST_IDLE);
	assign accept         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign corridor_clear = clear_q;
	assign out_free       = !out_valid_q || out_ready;

	// Commands decoded from the current state and the input handshake.
	always_comb begin
		cmd       = '0;
		cmd.axis  = axis_q;
		cmd.load  = accept;
		unique case (state_q)
			ST_PREP: cmd.prep  = 1'b1;
			ST_UPD:  cmd.upd   = 1'b1;
			ST_MUL2: cmd.step2 = 1'b1;
			ST_CHK:  cmd.step2 = 1'b1;
			default: ;
		endcase
	end

	// State, hit memory and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			hit_q       <= 1'b0;
			hit_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
			clear_q     <= 1'b0;
		end else begin
			// A last box in the finish state reloads the result register itself.
			if (out_valid_q && out_ready && !((state_q == ST_FINISH) && sts.last)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					axis_q <= 1'b0;
					if (!sts.enabled) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					if (!sts.dzero) begin
						state_q <= ST_UPD;
					end else if (!sts.contain) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else if (axis_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						axis_q <= 1'b1;
					end
				end
				ST_UPD: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (sts.miss) begin
						hit_q   <= 1'b0;
						state_q <= ST_FINISH;
					end else if (axis_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						axis_q  <= 1'b1;
						state_q <= ST_AXIS;
					end
				end
				ST_FINISH: begin
					// A last box waits here until the result register is free.
					if (!sts.last) begin
						hit_seen_q <= hit_seen_q | hit_q;
						state_q    <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						clear_q     <= !(hit_seen_q || hit_q);
						hit_seen_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench for segment_box_corridor_check_core: streams obstacle boxes and checks the
// corridor_clear result of each query against an exact slab-test predictor.
// Depends on sbc_pkg and the core RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sbc_pkg::*;

	localparam int    MAX_REPORTS    = 10;
	localparam int    IDLE_CYCLES    = 24;
	localparam int    HOLD_CYCLES    = 400;
	localparam int    WATCHDOG_LIMIT = 3000;
	localparam int    PHASE_ITEMS    = 160;
	localparam longint POS_MAX  = 64'sd2147483647;
	localparam longint POS_MIN  = -64'sd2147483648;
	localparam longint SIZE_MAX = 64'sd2147483647;

	// One obstacle transaction as it appears on the input ports.
	typedef struct packed {
		logic signed [POS_W-1:0] origin_x;
		logic signed [POS_W-1:0] origin_z;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_z;
		logic signed [POS_W-1:0] box_center_x;
		logic signed [POS_W-1:0] box_center_z;
		logic [SIZE_W-1:0]       box_size_x;
		logic [SIZE_W-1:0]       box_size_z;
		logic                    box_enabled;
		logic                    last_box;
	} box_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	cfg_reg_t                cfg_index = REG_LOOKAHEAD;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [POS_W-1:0] origin_x = '0;
	logic signed [POS_W-1:0] origin_z = '0;
	logic signed [DIR_W-1:0] dir_x = '0;
	logic signed [DIR_W-1:0] dir_z = '0;
	logic signed [POS_W-1:0] box_center_x = '0;
	logic signed [POS_W-1:0] box_center_z = '0;
	logic [SIZE_W-1:0]       box_size_x = '0;
	logic [SIZE_W-1:0]       box_size_z = '0;
	logic                    box_enabled = 1'b0;
	logic                    last_box = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    corridor_clear;

	// Predictor state: register copies, hit memory and pending results.
	logic [CFG_W-1:0] lookahead_q = LOOKAHEAD_RESET;
	logic [CFG_W-1:0] clearance_q = CLEARANCE_RESET;
	bit               hit_in_query = 1'b0;
	bit               clear_expected[$];
	int               mismatch_count = 0;

	// Stimulus pacing controls.
	bit tx_no_gaps = 1'b0;
	bit rx_no_stall = 1'b0;
	bit rx_hold_req = 1'b0;

	segment_box_corridor_check_core DUT (.*);

	always #2 clk = ~clk;

	// Narrows the interval [tmin, tmax] by one axis; returns 0 on a miss.
	// Positions come in doubled so that half a box size stays exact.
	function automatic bit clip_slab(input longint o2, input longint d,
			input longint lo2, input longint hi2,
			inout longint tmin_n, inout longint tmin_d,
			inout longint tmax_n, inout longint tmax_d);
		longint enter_n, leave_n, den;
		if (d == 0)
			return !(o2 < lo2 || o2 > hi2);
		if (d > 0) begin
			enter_n = lo2 - o2;
			leave_n = hi2 - o2;
			den = 2 * d;
		end else begin
			enter_n = o2 - hi2;
			leave_n = o2 - lo2;
			den = -2 * d;
		end
		if (tmin_n * den < enter_n * tmin_d) begin
			tmin_n = enter_n;
			tmin_d = den;
		end
		if (leave_n * tmax_d < tmax_n * den) begin
			tmax_n = leave_n;
			tmax_d = den;
		end
		return !(tmax_n * tmin_d < tmin_n * tmax_d);
	endfunction

	// True when the grown box meets the segment, touching included.
	function automatic bit box_meets_segment(input box_t b);
		longint r2, tmin_n, tmin_d, tmax_n, tmax_d;
		r2 = 2 * longint'(clearance_q);
		tmin_n = 0;
		tmin_d = 1;
		tmax_n = longint'(lookahead_q);
		tmax_d = longint'(1) << DIR_FRAC_BITS;
		if (!clip_slab(2 * longint'(b.origin_x), longint'(b.dir_x),
				2 * longint'(b.box_center_x) - longint'(b.box_size_x) - r2,
				2 * longint'(b.box_center_x) + longint'(b.box_size_x) + r2,
				tmin_n, tmin_d, tmax_n, tmax_d))
			return 1'b0;
		return clip_slab(2 * longint'(b.origin_z), longint'(b.dir_z),
				2 * longint'(b.box_center_z) - longint'(b.box_size_z) - r2,
				2 * longint'(b.box_center_z) + longint'(b.box_size_z) + r2,
				tmin_n, tmin_d, tmax_n, tmax_d);
	endfunction

	function automatic box_t box_fields(input longint ox, input longint oz,
			input longint dx, input longint dz, input longint cx, input longint cz,
			input longint sx, input longint sz, input bit en, input bit last);
		box_t b;
		b.origin_x = POS_W'(ox);
		b.origin_z = POS_W'(oz);
		b.dir_x = DIR_W'(dx);
		b.dir_z = DIR_W'(dz);
		b.box_center_x = POS_W'(cx);
		b.box_center_z = POS_W'(cz);
		b.box_size_x = SIZE_W'(sx);
		b.box_size_z = SIZE_W'(sz);
		b.box_enabled = en;
		b.last_box = last;
		return b;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input longint v);
		if (v > POS_MAX)
			return POS_W'(POS_MAX);
		if (v < POS_MIN)
			return POS_W'(POS_MIN);
		return POS_W'(v);
	endfunction

	// Uniform value in [-span, span].
	function automatic longint rand_offset(input longint span);
		longint unsigned u, m;
		u = {$urandom, $urandom};
		m = 2 * span + 1;
		return longint'(u % m) - span;
	endfunction

	// Sizes spread over every magnitude from zero up to the full field.
	function automatic logic [SIZE_W-1:0] rand_size();
		int unsigned w;
		longint mask;
		w = $urandom_range(0, SIZE_W);
		mask = (longint'(1) << w) - 1;
		return SIZE_W'(longint'($urandom) & mask);
	endfunction

	function automatic logic signed [DIR_W-1:0] rand_dir();
		return DIR_W'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic box_t noise_box();
		box_t b;
		b = box_fields($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
		return b;
	endfunction

	// Places a box close to a random point of the query path, jittered by about
	// its grown half width so that hits and misses come in similar numbers.
	function automatic box_t box_near_path(input box_t q);
		box_t b;
		longint f, px, pz, span_x, span_z;
		b = q;
		b.box_size_x = rand_size();
		b.box_size_z = rand_size();
		f = $urandom_range(0, 1280);
		px = longint'(q.origin_x) +
				(longint'(q.dir_x) * longint'(lookahead_q) * f) / (longint'(16384) * 1024);
		pz = longint'(q.origin_z) +
				(longint'(q.dir_z) * longint'(lookahead_q) * f) / (longint'(16384) * 1024);
		span_x = longint'(b.box_size_x) / 2 + longint'(clearance_q);
		span_x = span_x + span_x / 2 + 1;
		span_z = longint'(b.box_size_z) / 2 + longint'(clearance_q);
		span_z = span_z + span_z / 2 + 1;
		b.box_center_x = sat_pos(px + rand_offset(span_x));
		b.box_center_z = sat_pos(pz + rand_offset(span_z));
		return b;
	endfunction

	// Offers one transaction, waits for acceptance and updates the prediction.
	task automatic send_box(input box_t b);
		int gap;
		gap = tx_no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= b.origin_x;
		origin_z <= b.origin_z;
		dir_x <= b.dir_x;
		dir_z <= b.dir_z;
		box_center_x <= b.box_center_x;
		box_center_z <= b.box_center_z;
		box_size_x <= b.box_size_x;
		box_size_z <= b.box_size_z;
		box_enabled <= b.box_enabled;
		last_box <= b.last_box;
		do @(posedge clk); while (!in_ready);
		if (b.box_enabled && box_meets_segment(b))
			hit_in_query = 1'b1;
		if (b.last_box) begin
			clear_expected.push_back(!hit_in_query);
			hit_in_query = 1'b0;
		end
	endtask

	// Stops offering, waits for every pending result, then lets the block settle.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (clear_expected.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LOOKAHEAD)
			lookahead_q = value;
		else
			clearance_q = value;
	endtask

	// Queries of one to six boxes around a shared path, mixed with noise boxes.
	task automatic run_random_queries(input int item_budget);
		box_t q, b;
		int sent, n;
		sent = 0;
		while (sent < item_budget) begin
			q.origin_x = ($urandom_range(0, 9) < 3) ? $urandom : sat_pos(rand_offset(1 << 20));
			q.origin_z = ($urandom_range(0, 9) < 3) ? $urandom : sat_pos(rand_offset(1 << 20));
			case ($urandom_range(0, 19))
				0, 1: begin
					q.dir_x = '0;
					q.dir_z = rand_dir();
				end
				2, 3: begin
					q.dir_x = rand_dir();
					q.dir_z = '0;
				end
				4: begin
					q.dir_x = '0;
					q.dir_z = '0;
				end
				5: begin
					q.dir_x = DIR_W'($urandom);
					q.dir_z = DIR_W'($urandom);
				end
				default: begin
					q.dir_x = rand_dir();
					q.dir_z = rand_dir();
				end
			endcase
			tx_no_gaps = ($urandom_range(0, 4) == 0);
			rx_no_stall = ($urandom_range(0, 4) == 0);
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 10) begin
					b = noise_box();
				end else begin
					b = box_near_path(q);
					b.box_enabled = ($urandom_range(0, 99) >= 15);
					b.last_box = (i == n - 1);
				end
				send_box(b);
				sent++;
			end
			// Now and then let the pipeline drain completely before going on.
			if ($urandom_range(0, 19) == 0)
				wait_until_idle();
		end
		tx_no_gaps = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	// Touches at both ends, containment on zero axes, disabled boxes, hit memory
	// across a query, and the extremes of every field.
	task automatic test_directed_geometry();
		send_box(box_fields(0, 0, 16384, 0, 131072, 0, 65536, 0, 1, 1));
		send_box(box_fields(0, 0, 16384, 0, 131073, 0, 65536, 0, 1, 1));
		send_box(box_fields(0, 0, -16384, 0, 65536, 0, 65536, 0, 1, 1));
		send_box(box_fields(100, 200, 0, 0, 0, 0, 0, 0, 1, 1));
		send_box(box_fields(-32768, 0, 0, 0, 0, 0, 0, 0, 1, 1));
		send_box(box_fields(0, 32769, 0, 0, 0, 0, 0, 0, 1, 1));
		send_box(box_fields(0, 0, 16384, 0, 131072, 0, 65536, 0, 0, 1));
		send_box(box_fields(0, 0, 16384, 0, 131073, 0, 65536, 0, 1, 0));
		send_box(box_fields(0, 0, 16384, 0, 131072, 0, 65536, 0, 1, 0));
		send_box(box_fields(0, 0, 16384, 0, 131072, 0, 65536, 0, 0, 1));
		send_box(box_fields(0, 0, 16384, 0, 131073, 0, 65536, 0, 1, 1));
		send_box(box_fields(POS_MIN, POS_MAX, -32768, 32767, POS_MAX, POS_MIN,
				SIZE_MAX, SIZE_MAX, 1, 1));
		send_box(box_fields(POS_MAX, POS_MIN, 32767, -32768, POS_MIN, POS_MAX, 0, 0, 1, 1));
		send_box(box_fields(0, 0, 16384, -16384, 65536, -65536, 0, 0, 1, 1));
		send_box(box_fields(0, 0, 32767, 32767, 196608, 196608, 65536, 65536, 1, 1));
		send_box(box_fields(POS_MIN, POS_MIN, -16384, -16384, POS_MIN, POS_MIN,
				SIZE_MAX, 0, 1, 0));
		send_box(box_fields(POS_MAX, POS_MAX, 16384, 16384, POS_MAX, POS_MAX, 0, 0, 0, 1));
		wait_until_idle();
	endtask

	// With a zero lookahead the segment shrinks to its origin point.
	task automatic test_zero_lookahead();
		write_reg(REG_LOOKAHEAD, '0);
		send_box(box_fields(0, 0, 16384, 16384, 0, 0, 0, 0, 1, 1));
		send_box(box_fields(0, 0, 16384, 0, 131072, 0, 0, 0, 1, 1));
		send_box(box_fields(32768, -32768, -16384, 0, 0, 0, 0, 0, 1, 1));
		wait_until_idle();
	endtask

	// The receiver holds off for a long stretch while boxes keep coming.
	task automatic test_output_backpressure();
		box_t q, b;
		write_reg(REG_LOOKAHEAD, LOOKAHEAD_RESET);
		q = box_fields(0, 0, 16384, 8192, 0, 0, 0, 0, 1, 1);
		rx_hold_req = 1'b1;
		tx_no_gaps = 1'b1;
		for (int i = 0; i < 40; i++) begin
			b = box_near_path(q);
			b.box_enabled = 1'b1;
			b.last_box = (i % 2 == 0);
			send_box(b);
		end
		tx_no_gaps = 1'b0;
		wait_until_idle();
	endtask

	// Random traffic under several register settings, extremes included.
	task automatic test_config_sweep();
		logic [CFG_W-1:0] look, clr;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					look = LOOKAHEAD_RESET;
					clr = CLEARANCE_RESET;
				end
				1: begin
					look = '0;
					clr = '0;
				end
				2: begin
					look = '1;
					clr = '1;
				end
				3: begin
					look = '0;
					clr = '1;
				end
				4: begin
					look = '1;
					clr = '0;
				end
				5: begin
					look = CFG_W'($urandom_range(1, 1 << 22));
					clr = CFG_W'($urandom_range(0, 1 << 20));
				end
				default: begin
					look = CFG_W'($urandom);
					clr = CFG_W'($urandom);
				end
			endcase
			wait_until_idle();
			write_reg(REG_LOOKAHEAD, look);
			write_reg(REG_CLEARANCE, clr);
			run_random_queries(PHASE_ITEMS);
		end
		wait_until_idle();
	endtask

	// Main sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_geometry();
		test_zero_lookahead();
		test_output_backpressure();
		test_config_sweep();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result receiver: random stalls per transaction, or one long hold on request.
	initial begin : result_receiver
		int stall;
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = rx_no_stall ? 0 : $urandom_range(0, 5);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each result transaction with the oldest pending expectation.
	always @(posedge clk) begin : result_check
		bit exp_clear;
		if (out_valid && out_ready) begin
			if (clear_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: corridor_clear=%0b with no query pending",
							$realtime, corridor_clear);
			end else begin
				exp_clear = clear_expected.pop_front();
				if (corridor_clear !== exp_clear) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: corridor_clear expected %0b, got %0b",
								$realtime, exp_clear, corridor_clear);
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
